### rtl/llop_pkg.sv
// ----------------------------------------------------------------------------
// llop_pkg : shared definitions for the least loaded object placer
// field widths, mode codes, parameter defaults and the directory entry type
// ----------------------------------------------------------------------------
package llop_pkg;

   // field widths of the request and response words
   localparam int MODE_W          = 1;
   localparam int REQUEST_TAG_W   = 16;
   localparam int OBJECT_INDEX_W  = 8;
   localparam int SIZE_W          = 32;
   localparam int TAG_W           = 32;
   localparam int BUCKET_OUT_W    = 3;
   localparam int BUCKET_COUNT_W  = 4;

   // number of distinct object index codes
   localparam int OBJECT_INDEX_CODES = 2 ** OBJECT_INDEX_W;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_READ  = 1'b0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 1'b1;

   // parameter defaults
   localparam int DEF_MAX_BUCKETS  = 8;
   localparam int DEF_OBJECT_SLOTS = 256;
   localparam int DEF_LOAD_WIDTH   = 48;

   // bucket count after reset
   localparam logic [BUCKET_COUNT_W-1:0] BUCKET_COUNT_RESET = 4'd2;

   // one directory entry: written flag and recorded bucket
   typedef struct packed {
      logic                    written;
      logic [BUCKET_OUT_W-1:0] bucket;
   } dir_entry_type;

endpackage

### rtl/llop_req_if.sv
// ----------------------------------------------------------------------------
// llop_req_if : request channel
// valid/ready handshake carrying one read or write request word
// ----------------------------------------------------------------------------
interface llop_req_if import llop_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [REQUEST_TAG_W-1:0]  request_tag;
   logic [OBJECT_INDEX_W-1:0] object_index;
   logic [SIZE_W-1:0]         size_bytes;
   logic [TAG_W-1:0]          tag_value;

   modport source (
      output valid, mode, request_tag, object_index, size_bytes, tag_value,
      input  ready
   );

   modport sink (
      input  valid, mode, request_tag, object_index, size_bytes, tag_value,
      output ready
   );

endinterface

### rtl/llop_rsp_if.sv
// ----------------------------------------------------------------------------
// llop_rsp_if : response channel
// valid/ready handshake carrying one placement or lookup answer word
// ----------------------------------------------------------------------------
interface llop_rsp_if import llop_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [REQUEST_TAG_W-1:0] request_tag_out;
   logic [MODE_W-1:0]        mode_out;
   logic [BUCKET_OUT_W-1:0]  bucket;
   logic [TAG_W-1:0]         tag_out;
   logic                     found;

   modport source (
      output valid, request_tag_out, mode_out, bucket, tag_out, found,
      input  ready
   );

   modport sink (
      input  valid, request_tag_out, mode_out, bucket, tag_out, found,
      output ready
   );

endinterface

### rtl/least_loaded_object_placer.sv
// ----------------------------------------------------------------------------
// least_loaded_object_placer : places objects on the least loaded bucket
// and answers object lookups from a directory
// channels: req (sink) takes one word per object, mode 1 places the object on
// the enabled bucket with the smallest byte total (lowest index on a tie),
// mode 0 looks it up; rsp (source) returns exactly one word per request, in
// order. csr_wr_en/csr_wr_data set the number of buckets in use; a value of
// zero counts as one, a value above MAX_BUCKETS as MAX_BUCKETS
// operation: one request is in flight at a time. a lookup reads the directory
// on acceptance (registered read) and loads the response register from its
// commit state. a placement launches a search word that walks the bucket
// chain one cell per cycle, then the commit state updates the load and the
// directory, once the response register is free, and loads the response.
// req_ready rises in the cycle after the response load
// reset: synchronous, active high. bucket totals clear at once; the directory
// then runs a clearing pass over all OBJECT_SLOTS entries with req_ready low
// stall: the response register holds its word until taken; one more request
// is still accepted meanwhile and waits in its commit state until it is free
// ----------------------------------------------------------------------------
module least_loaded_object_placer import llop_pkg::*; #(
   parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
   parameter int OBJECT_SLOTS = DEF_OBJECT_SLOTS,
   parameter int LOAD_WIDTH   = DEF_LOAD_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [BUCKET_COUNT_W-1:0] csr_wr_data,
   llop_req_if.sink                  req,
   llop_rsp_if.source                rsp
);

   localparam int BUCKET_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SLOT_W   = $clog2(OBJECT_SLOTS);

   // controller states
   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_SEARCH  = 3'd2;
   localparam logic [2:0] ST_WCOMMIT = 3'd3;
   localparam logic [2:0] ST_RCOMMIT = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [SLOT_W-1:0]         clr_ctr_ff, clr_ctr_in;
   logic [BUCKET_COUNT_W-1:0] bucket_count_ff, bucket_count_in;
   logic [BUCKET_COUNT_W-1:0] bucket_count_eff;
   logic                      launch_ff, launch_in;

   // latched request word
   logic [REQUEST_TAG_W-1:0]  rtag_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [SIZE_W-1:0]         size_ff;
   logic [TAG_W-1:0]          tag_ff;
   logic [BUCKET_W-1:0]       best_ff, best_in;
   logic [BUCKET_W+2:0]       best_wide;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [REQUEST_TAG_W-1:0]  rsp_rtag_ff;
   logic [MODE_W-1:0]         rsp_mode_ff;
   logic [BUCKET_OUT_W-1:0]   rsp_bucket_ff;
   logic [TAG_W-1:0]          rsp_tag_ff;
   logic                      rsp_found_ff;
   logic                      rsp_free;
   logic                      rsp_load_wr, rsp_load_rd;

   // search chain
   logic [MAX_BUCKETS:0]      tok_valid;
   logic [LOAD_WIDTH-1:0]     tok_load [MAX_BUCKETS+1];
   logic [BUCKET_W-1:0]       tok_idx  [MAX_BUCKETS+1];
   logic                      upd_en;

   // object index to directory slot, worked out at elaboration
   logic [SLOT_W-1:0]         slot_tab [OBJECT_INDEX_CODES];
   logic [SLOT_W-1:0]         req_slot;
   logic                      accept;

   // directory ports
   logic                      dir_wr_en, dir_wr_tag_en;
   logic [SLOT_W-1:0]         dir_wr_addr;
   dir_entry_type             dir_wr_entry;
   dir_entry_type             dir_rd_entry;
   logic [TAG_W-1:0]          dir_rd_tag;

   for (genvar g = 0; g < OBJECT_INDEX_CODES; g++) begin : g_slot
      assign slot_tab[g] = SLOT_W'(g % OBJECT_SLOTS);
   end

   assign req_slot = slot_tab[req.object_index];
   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);

   // bucket count with zero and overrange folded in
   always_comb begin
      if (bucket_count_ff == '0) begin
         bucket_count_eff = BUCKET_COUNT_W'(1);
      end else if (int'(bucket_count_ff) > MAX_BUCKETS) begin
         bucket_count_eff = BUCKET_COUNT_W'(MAX_BUCKETS);
      end else begin
         bucket_count_eff = bucket_count_ff;
      end
   end

   assign bucket_count_in = csr_wr_en ? csr_wr_data : bucket_count_ff;

   // chain head: a search word that any enabled, unsaturated bucket beats, bucket 0 by default
   assign tok_valid[0] = launch_ff;
   assign tok_load[0]  = '1;
   assign tok_idx[0]   = '0;

   for (genvar c = 0; c < MAX_BUCKETS; c++) begin : g_cell
      llop_cell #(
         .INDEX      (c),
         .LOAD_WIDTH (LOAD_WIDTH),
         .BUCKET_W   (BUCKET_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .bucket_count  (bucket_count_eff),
         .tok_valid_in  (tok_valid[c]),
         .tok_load_in   (tok_load[c]),
         .tok_idx_in    (tok_idx[c]),
         .tok_valid_out (tok_valid[c+1]),
         .tok_load_out  (tok_load[c+1]),
         .tok_idx_out   (tok_idx[c+1]),
         .upd_en        (upd_en),
         .upd_idx       (best_ff),
         .upd_size      (size_ff)
      );
   end

   // response register takes a word only once the previous one has gone
   assign rsp_free    = !rsp_valid_ff || rsp.ready;
   assign rsp_load_wr = (state_ff == ST_WCOMMIT) && rsp_free;
   assign rsp_load_rd = (state_ff == ST_RCOMMIT) && rsp_free;
   assign upd_en      = rsp_load_wr;
   assign best_wide   = {3'b000, best_ff};

   // directory writes: clearing pass after reset, placements afterwards
   always_comb begin
      dir_wr_en      = 1'b0;
      dir_wr_tag_en  = 1'b0;
      dir_wr_addr    = slot_ff;
      dir_wr_entry   = '0;
      if (state_ff == ST_CLEAR) begin
         dir_wr_en   = 1'b1;
         dir_wr_addr = clr_ctr_ff;
      end else if (rsp_load_wr) begin
         dir_wr_en            = 1'b1;
         dir_wr_tag_en        = 1'b1;
         dir_wr_entry.written = 1'b1;
         dir_wr_entry.bucket  = best_wide[BUCKET_OUT_W-1:0];
      end
   end

   llop_directory #(
      .OBJECT_SLOTS (OBJECT_SLOTS),
      .SLOT_W       (SLOT_W)
   ) u_directory (
      .clock     (clock),
      .wr_en     (dir_wr_en),
      .wr_tag_en (dir_wr_tag_en),
      .wr_addr   (dir_wr_addr),
      .wr_entry  (dir_wr_entry),
      .wr_tag    (tag_ff),
      .rd_en     (accept),
      .rd_addr   (req_slot),
      .rd_entry  (dir_rd_entry),
      .rd_tag    (dir_rd_tag)
   );

   // controller
   always_comb begin
      state_in   = state_ff;
      clr_ctr_in = clr_ctr_ff;
      launch_in  = 1'b0;
      best_in    = best_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_ctr_in = clr_ctr_ff + SLOT_W'(1);
            if (clr_ctr_ff == SLOT_W'(OBJECT_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.mode == MODE_WRITE) begin
                  launch_in = 1'b1;
                  state_in  = ST_SEARCH;
               end else begin
                  state_in  = ST_RCOMMIT;
               end
            end
         end
         ST_SEARCH: begin
            // search word leaves the last cell holding the winner
            if (tok_valid[MAX_BUCKETS]) begin
               best_in  = tok_idx[MAX_BUCKETS];
               state_in = ST_WCOMMIT;
            end
         end
         ST_WCOMMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_RCOMMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load_wr || rsp_load_rd) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ctr_ff      <= '0;
         launch_ff       <= 1'b0;
         bucket_count_ff <= BUCKET_COUNT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_ctr_ff      <= clr_ctr_in;
         launch_ff       <= launch_in;
         bucket_count_ff <= bucket_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         rtag_ff <= req.request_tag;
         slot_ff <= req_slot;
         size_ff <= req.size_bytes;
         tag_ff  <= req.tag_value;
      end
      best_ff <= best_in;
   end

   // response word: placement answers carry no tag and no found flag
   always_ff @(posedge clock) begin
      if (rsp_load_wr) begin
         rsp_rtag_ff   <= rtag_ff;
         rsp_mode_ff   <= MODE_WRITE;
         rsp_bucket_ff <= best_wide[BUCKET_OUT_W-1:0];
         rsp_tag_ff    <= '0;
         rsp_found_ff  <= 1'b0;
      end else if (rsp_load_rd) begin
         rsp_rtag_ff   <= rtag_ff;
         rsp_mode_ff   <= MODE_READ;
         rsp_bucket_ff <= dir_rd_entry.written ? dir_rd_entry.bucket : '0;
         rsp_tag_ff    <= dir_rd_entry.written ? dir_rd_tag : '0;
         rsp_found_ff  <= dir_rd_entry.written;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.request_tag_out = rsp_rtag_ff;
   assign rsp.mode_out        = rsp_mode_ff;
   assign rsp.bucket          = rsp_bucket_ff;
   assign rsp.tag_out         = rsp_tag_ff;
   assign rsp.found           = rsp_found_ff;

   // at most one search word in the chain
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one search word in the bucket chain");

   // the winner only emerges while a placement is searching
   a_exit_in_search: assert property (@(posedge clock) disable iff (reset)
      tok_valid[MAX_BUCKETS] |-> (state_ff == ST_SEARCH))
      else $error("search word left the chain outside a placement");

   // one request at a time
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("request taken while another is in flight");

endmodule

### rtl/llop_cell.sv
// ----------------------------------------------------------------------------
// llop_cell : one bucket of the placement chain
// holds the bucket byte total, refines the passing minimum search word and
// adds a placed object's size with saturation
// ----------------------------------------------------------------------------
module llop_cell import llop_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int LOAD_WIDTH = DEF_LOAD_WIDTH,
   parameter int BUCKET_W   = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [BUCKET_COUNT_W-1:0] bucket_count,
   input  logic                      tok_valid_in,
   input  logic [LOAD_WIDTH-1:0]     tok_load_in,
   input  logic [BUCKET_W-1:0]       tok_idx_in,
   output logic                      tok_valid_out,
   output logic [LOAD_WIDTH-1:0]     tok_load_out,
   output logic [BUCKET_W-1:0]       tok_idx_out,
   input  logic                      upd_en,
   input  logic [BUCKET_W-1:0]       upd_idx,
   input  logic [SIZE_W-1:0]         upd_size
);

   localparam int SUM_W = ((LOAD_WIDTH > SIZE_W) ? LOAD_WIDTH : SIZE_W) + 1;

   logic [LOAD_WIDTH-1:0] bucket_load_ff, bucket_load_in;
   logic                  tok_valid_ff, tok_valid_in_nx;
   logic [LOAD_WIDTH-1:0] tok_load_ff, tok_load_in_nx;
   logic [BUCKET_W-1:0]   tok_idx_ff, tok_idx_in_nx;
   logic                  enabled;
   logic [SUM_W-1:0]      sum;

   assign enabled = int'(bucket_count) > INDEX;

   // saturating add of the placed size
   assign sum = SUM_W'(bucket_load_ff) + SUM_W'(upd_size);

   always_comb begin
      bucket_load_in = bucket_load_ff;
      if (upd_en && (upd_idx == BUCKET_W'(INDEX))) begin
         if (sum[SUM_W-1:LOAD_WIDTH] != '0) begin
            bucket_load_in = '1;
         end else begin
            bucket_load_in = sum[LOAD_WIDTH-1:0];
         end
      end
   end

   // strict compare keeps the lower index on a tie
   always_comb begin
      tok_valid_in_nx = tok_valid_in;
      tok_load_in_nx  = tok_load_in;
      tok_idx_in_nx   = tok_idx_in;
      if (enabled && (bucket_load_ff < tok_load_in)) begin
         tok_load_in_nx = bucket_load_ff;
         tok_idx_in_nx  = BUCKET_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_load_ff <= '0;
         tok_valid_ff   <= 1'b0;
      end else begin
         bucket_load_ff <= bucket_load_in;
         tok_valid_ff   <= tok_valid_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      tok_load_ff <= tok_load_in_nx;
      tok_idx_ff  <= tok_idx_in_nx;
   end

   assign tok_valid_out = tok_valid_ff;
   assign tok_load_out  = tok_load_ff;
   assign tok_idx_out   = tok_idx_ff;

endmodule

### rtl/llop_directory.sv
// ----------------------------------------------------------------------------
// llop_directory : object directory
// entry memory (written flag and bucket) and tag memory, one write and one
// registered read per cycle
// ----------------------------------------------------------------------------
module llop_directory import llop_pkg::*; #(
   parameter int OBJECT_SLOTS = DEF_OBJECT_SLOTS,
   parameter int SLOT_W       = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic                wr_tag_en,
   input  logic [SLOT_W-1:0]   wr_addr,
   input  dir_entry_type       wr_entry,
   input  logic [TAG_W-1:0]    wr_tag,
   input  logic                rd_en,
   input  logic [SLOT_W-1:0]   rd_addr,
   output dir_entry_type       rd_entry,
   output logic [TAG_W-1:0]    rd_tag
);

   dir_entry_type    entry_mem [OBJECT_SLOTS];
   logic [TAG_W-1:0] tag_mem   [OBJECT_SLOTS];
   dir_entry_type    rd_entry_ff;
   logic [TAG_W-1:0] rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_tag_en) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (rd_en) begin
         rd_tag_ff <= tag_mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_tag   = rd_tag_ff;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench : self-checking bench for the least loaded object placer
// a clocked driver feeds request words from a queue with bursts and gaps, a
// clocked monitor stalls the response channel on its own pattern and checks
// every response word against a predictor of the bucket totals and directory
// ----------------------------------------------------------------------------
module testbench;
   import llop_pkg::*;

   localparam int MAX_BUCKETS      = DEF_MAX_BUCKETS;
   localparam int OBJECT_SLOTS     = DEF_OBJECT_SLOTS;
   localparam int LOAD_WIDTH       = DEF_LOAD_WIDTH;
   localparam logic [LOAD_WIDTH-1:0] LOAD_MAX = '1;

   // slowest correct run: about 750 words, with heavy response stalls, gaps,
   // the long hold-off and the directory clear
   localparam int CYCLE_LIMIT      = 300_000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = 16;
   localparam int FILL_WORDS       = 20;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [REQUEST_TAG_W-1:0]  request_tag;
      logic [OBJECT_INDEX_W-1:0] object_index;
      logic [SIZE_W-1:0]         size_bytes;
      logic [TAG_W-1:0]          tag_value;
   } request_word_type;

   typedef struct packed {
      logic [REQUEST_TAG_W-1:0] request_tag_out;
      logic [MODE_W-1:0]        mode_out;
      logic [BUCKET_OUT_W-1:0]  bucket;
      logic [TAG_W-1:0]         tag_out;
      logic                     found;
   } answer_word_type;

   // clock, reset and configuration port, all known from time zero
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [BUCKET_COUNT_W-1:0] csr_wr_data = '0;

   llop_req_if req_bus ();
   llop_rsp_if rsp_bus ();

   least_loaded_object_placer uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .rsp         (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor state: a copy of the bucket totals, the directory and the
   // bucket count register as the block should hold them
   // ------------------------------------------------------------------------
   logic [LOAD_WIDTH-1:0]     bucket_total [MAX_BUCKETS];
   logic [BUCKET_OUT_W-1:0]   dir_bucket   [OBJECT_SLOTS];
   logic                      dir_written  [OBJECT_SLOTS];
   logic [TAG_W-1:0]          dir_tag      [OBJECT_SLOTS];
   logic [BUCKET_COUNT_W-1:0] bucket_count_q = BUCKET_COUNT_RESET;

   // words waiting to be offered, and answers waiting to come back
   request_word_type pending_words [$];
   answer_word_type  expected_answers [$];

   // shared flags between the sequencer and the two clocked processes
   logic bulk_fill      = 1'b0;
   logic long_hold_req  = 1'b0;
   logic long_hold_done = 1'b0;

   int unsigned mismatch_count    = 0;
   int unsigned answers_checked   = 0;
   int unsigned placements_seen   = 0;
   int unsigned lookups_seen      = 0;
   int unsigned misses_seen       = 0;
   int unsigned settings_written  = 0;
   int unsigned cycle_count       = 0;
   logic        total_saturated   = 1'b0;
   logic [15:0] next_request_tag  = '0;

   initial begin
      for (int i = 0; i < MAX_BUCKETS; i++) bucket_total[i] = '0;
      for (int i = 0; i < OBJECT_SLOTS; i++) begin
         dir_bucket[i]  = '0;
         dir_written[i] = 1'b0;
         dir_tag[i]     = '0;
      end
   end

   // works out the answer to one accepted word and updates the copy of the
   // block state the way the block itself must
   function automatic answer_word_type predict_answer(request_word_type w);
      answer_word_type       a;
      int unsigned           lanes;
      int unsigned           best;
      int unsigned           slot;
      logic [LOAD_WIDTH:0]   sum;
      a                 = '0;
      a.request_tag_out = w.request_tag;
      a.mode_out        = w.mode;
      slot              = int'(w.object_index) % OBJECT_SLOTS;
      if (w.mode == MODE_WRITE) begin
         // a count of zero still leaves one bucket, anything above the
         // bucket array is clipped to its size
         if (bucket_count_q == 0) lanes = 1;
         else if (bucket_count_q > MAX_BUCKETS) lanes = MAX_BUCKETS;
         else lanes = int'(bucket_count_q);
         // strict less-than keeps the lowest index on a tie
         best = 0;
         for (int unsigned i = 1; i < lanes; i++)
            if (bucket_total[i] < bucket_total[best]) best = i;
         sum = {1'b0, bucket_total[best]} + w.size_bytes;
         if (sum > LOAD_MAX) begin
            bucket_total[best] = LOAD_MAX;
            total_saturated    = 1'b1;
         end else begin
            bucket_total[best] = sum[LOAD_WIDTH-1:0];
         end
         // a rewrite moves the record only, the old bucket keeps its total
         dir_bucket[slot]  = BUCKET_OUT_W'(best);
         dir_written[slot] = 1'b1;
         dir_tag[slot]     = w.tag_value;
         a.bucket          = BUCKET_OUT_W'(best);
         placements_seen++;
      end else begin
         lookups_seen++;
         if (dir_written[slot]) begin
            a.bucket  = dir_bucket[slot];
            a.tag_out = dir_tag[slot];
            a.found   = 1'b1;
         end else begin
            misses_seen++;
         end
      end
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // driver: offers pending words in bursts of random length with random
   // gaps, holds a word until it is taken, predicts it on acceptance
   // ------------------------------------------------------------------------
   request_word_type offered_word;
   int unsigned      burst_left = 0;
   int unsigned      gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left    = 0;
         gap_left      = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_answers.insert(expected_answers.size(), predict_answer(offered_word));
         // a word still waiting for ready stays on the bus untouched
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0 && !bulk_fill) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               offered_word           = pending_words.pop_front();
               req_bus.mode         <= offered_word.mode;
               req_bus.request_tag  <= offered_word.request_tag;
               req_bus.object_index <= offered_word.object_index;
               req_bus.size_bytes   <= offered_word.size_bytes;
               req_bus.tag_value    <= offered_word.tag_value;
               req_bus.valid        <= 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  // about a quarter of bursts run straight into the next
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: checks each accepted response word against the oldest
   // expectation and drives ready on a stall pattern of its own
   // ------------------------------------------------------------------------
   answer_word_type want;
   int unsigned     stall_style = 0;
   int unsigned     style_left  = 0;
   int unsigned     hold_left   = 0;

   task automatic check_field(string name, logic [31:0] expected_val, logic [31:0] actual_val);
      if (actual_val !== expected_val) begin
         $error("%s: expected %0h, got %0h", name, expected_val, actual_val);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_answers.size() == 0) begin
               $error("response word with nothing expected, request tag %0h",
                      rsp_bus.request_tag_out);
               mismatch_count++;
            end else begin
               want = expected_answers.pop_front();
               check_field("request_tag_out", want.request_tag_out, rsp_bus.request_tag_out);
               check_field("mode_out", want.mode_out, rsp_bus.mode_out);
               check_field("bucket", want.bucket, rsp_bus.bucket);
               check_field("tag_out", want.tag_out, rsp_bus.tag_out);
               check_field("found", want.found, rsp_bus.found);
               answers_checked++;
            end
         end
         // one long hold-off, counted here, so the block fills and stalls
         if (long_hold_req && !long_hold_done) begin
            hold_left      = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(32, 256);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (bulk_fill) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            case (stall_style)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequencer helpers; they look at the bench at the falling edge, when
   // everything from the rising edge has settled
   // ------------------------------------------------------------------------
   task automatic queue_word(logic [MODE_W-1:0] mode, logic [15:0] rtag,
                             logic [7:0] obj, logic [31:0] size, logic [31:0] tagv);
      request_word_type w;
      w.mode         = mode;
      w.request_tag  = rtag;
      w.object_index = obj;
      w.size_bytes   = size;
      w.tag_value    = tagv;
      pending_words.insert(pending_words.size(), w);
   endtask

   // sender stops until every outstanding answer is back
   task automatic wait_idle();
      @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_answers.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_bucket_count(logic [BUCKET_COUNT_W-1:0] value);
      wait_idle();
      // let ready return to the request side before touching the register
      repeat (2) @(negedge clock);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      bucket_count_q = value;
      settings_written++;
      @(negedge clock);
   endtask

   // mostly a small hot set of objects so lookups find something
   function automatic logic [7:0] pick_object();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(0, 15));
         1: return 8'($urandom_range(240, 255));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] pick_size();
      case ($urandom_range(0, 7))
         0, 1: return '0;
         2, 3: return 32'($urandom_range(0, 15));
         4: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_random_words(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         queue_word(($urandom_range(0, 99) < 55) ? MODE_WRITE : MODE_READ,
                    16'($urandom_range(0, 16'hFFFF)), pick_object(), pick_size(), $urandom);
      end
   endtask

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   int unsigned random_counts [10] = '{1, 8, 4, 15, 0, 3, 7, 9, 2, 5};

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_READ;
      req_bus.request_tag  = '0;
      req_bus.object_index = '0;
      req_bus.size_bytes   = '0;
      req_bus.tag_value    = '0;
      rsp_bus.ready        = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset bucket count of two: lookups of unwritten objects,
      // ties on empty buckets, extreme sizes, tags and indices, a rewrite
      queue_word(MODE_READ,  16'h0000, 8'd0,   32'h0,        32'h0);
      queue_word(MODE_READ,  16'hFFFF, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_word(MODE_WRITE, 16'h0001, 8'd0,   32'h0,        32'h0);
      queue_word(MODE_WRITE, 16'hFFFE, 8'd255, 32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_word(MODE_WRITE, 16'h0002, 8'd1,   32'h1,        32'h5A5A5A5A);
      queue_word(MODE_WRITE, 16'h0003, 8'd2,   32'hFFFFFFFF, 32'hA5A5A5A5);
      queue_word(MODE_READ,  16'h0004, 8'd0,   32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_word(MODE_READ,  16'h0005, 8'd255, 32'h0,        32'h0);
      queue_word(MODE_READ,  16'h0006, 8'd1,   32'h0,        32'h0);
      queue_word(MODE_WRITE, 16'h0007, 8'd255, 32'h7,        32'h12345678);
      queue_word(MODE_READ,  16'h0008, 8'd255, 32'h0,        32'h0);

      // count of zero behaves as one bucket
      set_bucket_count(4'd0);
      queue_word(MODE_WRITE, 16'h0010, 8'd3, 32'h3, 32'hCAFE0003);
      queue_word(MODE_READ,  16'h0011, 8'd3, 32'h0, 32'h0);

      // count above the array is clipped; fill the untouched buckets in order
      set_bucket_count(4'd15);
      for (int i = 0; i < 6; i++)
         queue_word(MODE_WRITE, 16'(16'h0020 + i), 8'(16 + i), 32'h1, 32'(32'hB0000000 + i));
      queue_word(MODE_WRITE, 16'h0030, 8'd22, 32'h0, 32'h0F0F0F0F);
      queue_word(MODE_READ,  16'h0031, 8'd21, 32'h0, 32'h0);

      // random part over several counts, each with a drain halfway
      foreach (random_counts[k]) begin
         set_bucket_count(random_counts[k][BUCKET_COUNT_W-1:0]);
         queue_random_words(35);
         if (k == 1) long_hold_req = 1'b1;
         wait_idle();
         queue_random_words(32);
      end

      // a run of maximum sizes piled onto bucket zero, back to back
      set_bucket_count(4'd1);
      bulk_fill  = 1'b1;
      for (int unsigned i = 0; i < FILL_WORDS; i++) begin
         queue_word(MODE_WRITE, next_request_tag, pick_object(), 32'hFFFFFFFF, $urandom);
         next_request_tag++;
      end
      wait_idle();
      bulk_fill = 1'b0;
      queue_random_words(20);
      set_bucket_count(4'd8);
      queue_random_words(20);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d answer words: %0d placements, %0d lookups, %0d of them misses",
               answers_checked, placements_seen, lookups_seen, misses_seen);
      $display("%0d bucket count writes, total saturation %s, long response hold-off %s",
               settings_written, total_saturated ? "reached" : "not reached",
               long_hold_done ? "done" : "not done");
      if (mismatch_count == 0 && expected_answers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
